>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication checked on the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mrpt_pkg.sv
package mrpt_pkg;

  // Width of a table base and of a base index.
  localparam int BASE_W     = 6;
  localparam int TABLE_SIZE = 12;
  localparam int IDX_W      = 4;

  typedef logic [BASE_W-1:0] base_t;

  // Fixed witness bases, used in order.
  localparam base_t BASE_TABLE [TABLE_SIZE] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
  };

  // Status reported by the modular multiplier to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

>>> rtl/core/mrpt_modmul.sv
`include "assert_macros.svh"

// Bit-serial modular multiplier: one bit of b per cycle, double then add,
// each followed by a conditional subtract of the modulus.
module mrpt_modmul #(
  parameter int W = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  input  logic [W-1:0]      n_i,
  output mrpt_pkg::mm_stat_t stat_o,
  output logic [W-1:0]      result_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     r_q, r_d;
  logic [W-1:0]     a_q;
  logic [W-1:0]     b_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [W:0]   dbl;
  logic [W-1:0] rd;
  logic [W:0]   sum;
  logic [W-1:0] rs;

  // One shift-and-add step of the product.
  always_comb begin
    dbl = {r_q, 1'b0};
    rd  = (dbl >= {1'b0, n_i}) ? W'(dbl - {1'b0, n_i}) : dbl[W-1:0];
    sum = {1'b0, rd} + {1'b0, a_q};
    rs  = (sum >= {1'b0, n_i}) ? W'(sum - {1'b0, n_i}) : sum[W-1:0];
    r_d = b_q[W-1] ? rs : rd;
  end

  // Control: busy after a start until the bit counter runs out, then a one-cycle done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      r_q <= '0;
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= {b_q[W-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = r_q;

  `ASSERT_CLK(a_mm_reduced, !done_q || (r_q < n_i), "modmul result not below modulus")

endmodule

>>> rtl/core/miller_rabin_primality_test_unit.sv
// Miller-Rabin primality test. Each transaction on the input stream carries
// one unsigned candidate; one transaction on the output stream later says
// whether it is prime. The block handles one candidate at a time and is not
// ready while it works. All modular products run on one shared bit-serial
// modular multiplier. A base needs one or two products per bit of the odd
// part of n-1 for the power and one squaring per remaining bit of n-1, so at
// most about 2*log2(n) products; even inputs and inputs below 2 need none.
// The result is exact below about 3.8e18 and a strong-probable-prime
// verdict above that.
module miller_rabin_primality_test_unit #(
  parameter int VALUE_WIDTH = 63,
  parameter int NUM_BASES   = 9
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: candidate (VALUE_WIDTH bits), then zero fill
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: is_prime (bit 0), then zero fill
  output logic [7:0]                           m_axis_tdata
);

  localparam int W  = VALUE_WIDTH;
  localparam int NB = (NUM_BASES < 1) ? 1 :
                      ((NUM_BASES > mrpt_pkg::TABLE_SIZE) ? mrpt_pkg::TABLE_SIZE : NUM_BASES);
  localparam int IW = mrpt_pkg::IDX_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_FIND_D   = 4'd2;
  localparam logic [3:0] S_BASE     = 4'd3;
  localparam logic [3:0] S_REDUCE   = 4'd4;
  localparam logic [3:0] S_POW      = 4'd5;
  localparam logic [3:0] S_WAIT_ACC = 4'd6;
  localparam logic [3:0] S_WAIT_X   = 4'd7;
  localparam logic [3:0] S_SQ       = 4'd8;
  localparam logic [3:0] S_WAIT_SQ  = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [W-1:0]  n_q, d_q, e_q, t_q, acc_q, x_q;
  logic [IW-1:0] idx_q;
  logic          verdict_q;
  logic          out_valid_q, out_bit_q;

  logic [W-1:0]  nm1;
  logic [W-1:0]  base_ext;
  logic          mm_start;
  logic [W-1:0]  mm_a, mm_b, mm_res;
  mrpt_pkg::mm_stat_t mm_stat;

  assign nm1      = n_q - W'(1);
  assign base_ext = {{(W-mrpt_pkg::BASE_W){1'b0}}, mrpt_pkg::BASE_TABLE[idx_q]};

  // Shared modular multiplier.
  mrpt_modmul #(.W(W)) u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .a_i      (mm_a),
    .b_i      (mm_b),
    .n_i      (n_q),
    .stat_o   (mm_stat),
    .result_o (mm_res)
  );

  // Sequencer next state and multiplier requests.
  always_comb begin
    state_d  = state_q;
    mm_start = 1'b0;
    mm_a     = x_q;
    mm_b     = x_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_CHECK;
      end
      S_CHECK: begin
        if ((n_q < W'(2)) || ((n_q != W'(2)) && !n_q[0])) state_d = S_DONE;
        else state_d = S_FIND_D;
      end
      S_FIND_D: begin
        if ((d_q == '0) || d_q[0]) state_d = S_BASE;
      end
      S_BASE: begin
        if (n_q == base_ext) state_d = S_DONE;
        else state_d = S_REDUCE;
      end
      S_REDUCE: begin
        if (x_q < n_q) state_d = S_POW;
      end
      S_POW: begin
        if (e_q == '0) begin
          state_d = S_SQ;
        end else if (e_q[0]) begin
          mm_start = 1'b1;
          mm_a     = acc_q;
          state_d  = S_WAIT_ACC;
        end else begin
          mm_start = 1'b1;
          state_d  = S_WAIT_X;
        end
      end
      S_WAIT_ACC: begin
        if (mm_stat.done) begin
          mm_start = 1'b1;
          state_d  = S_WAIT_X;
        end
      end
      S_WAIT_X: begin
        if (mm_stat.done) state_d = S_POW;
      end
      S_SQ: begin
        if ((t_q != nm1) && (acc_q != W'(1)) && (acc_q != nm1)) begin
          mm_start = 1'b1;
          mm_a     = acc_q;
          mm_b     = acc_q;
          state_d  = S_WAIT_SQ;
        end else if (((acc_q != nm1) && !t_q[0]) || (idx_q == IW'(NB - 1))) begin
          state_d = S_DONE;
        end else begin
          state_d = S_BASE;
        end
      end
      S_WAIT_SQ: begin
        if (mm_stat.done) state_d = S_SQ;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        n_q <= s_axis_tdata[W-1:0];
      end
      S_CHECK: begin
        verdict_q <= 1'b0;
        d_q       <= nm1;
        idx_q     <= '0;
      end
      S_FIND_D: begin
        if ((d_q != '0) && !d_q[0]) d_q <= d_q >> 1;
      end
      S_BASE: begin
        verdict_q <= (n_q == base_ext);
        x_q       <= base_ext;
        acc_q     <= W'(1);
        e_q       <= d_q;
        t_q       <= d_q;
      end
      S_REDUCE: begin
        if (x_q >= n_q) x_q <= x_q - n_q;
      end
      S_WAIT_ACC: begin
        if (mm_stat.done) acc_q <= mm_res;
      end
      S_WAIT_X: begin
        if (mm_stat.done) begin
          x_q <= mm_res;
          e_q <= e_q >> 1;
        end
      end
      S_SQ: begin
        if (!((t_q != nm1) && (acc_q != W'(1)) && (acc_q != nm1))) begin
          if ((acc_q != nm1) && !t_q[0]) begin
            verdict_q <= 1'b0;
          end else begin
            verdict_q <= 1'b1;
            idx_q     <= idx_q + IW'(1);
          end
        end
      end
      S_WAIT_SQ: begin
        if (mm_stat.done) begin
          acc_q <= mm_res;
          t_q   <= t_q << 1;
        end
      end
      default: begin
      end
    endcase
    if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) out_bit_q <= verdict_q;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_bit_q};

  `ASSERT_CLK(a_idle_mm_free, !s_axis_tready || !mm_stat.busy,
              "multiplier busy while accepting a candidate")
  `ASSERT_CLK(a_done_in_wait, !mm_stat.done || (state_q == S_WAIT_ACC) ||
              (state_q == S_WAIT_X) || (state_q == S_WAIT_SQ),
              "multiplier result outside a wait state")
  `ASSERT_NEXT(a_start_busy, mm_start && !mm_stat.busy, mm_stat.busy,
               "multiplier did not start")

endmodule

>>> sim/miller_rabin_primality_test_unit_tb.sv
module miller_rabin_primality_test_unit_tb;

  localparam int VALUE_WIDTH = 63;
  localparam int NUM_BASES   = 9;
  localparam int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int WATCHDOG    = 600000;
  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;

  // Verdicts still owed by the block, oldest first.
  bit   pending_verdicts [$];
  int   src_idle_pct;
  int   snk_stall_pct;
  int   mismatches;
  int   sent_count;
  int   checked_count;
  int   prime_count;
  int   idle_cycles;

  miller_rabin_primality_test_unit #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_BASES  (NUM_BASES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock with a period of 8.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Exact modular product by shift and add; n is below 2^63 so nothing overflows.
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] r;
    r = 64'd0;
    for (int i = 62; i >= 0; i--) begin
      r = r + r;
      if (r >= n) r = r - n;
      if (b[i]) begin
        r = r + a;
        if (r >= n) r = r - n;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] x, logic [63:0] e, logic [63:0] n);
    logic [63:0] acc;
    acc = 64'd1 % n;
    x = x % n;
    while (e != 64'd0) begin
      if (e[0]) acc = mulmod(acc, x, n);
      x = mulmod(x, x, n);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Strong-probable-prime test over the leading table bases.
  function automatic bit primality_verdict(logic [63:0] raw);
    logic [63:0] n, nm1, d, t, m, x;
    int k;
    n = raw & VALUE_MASK;
    if (n < 64'd2) return 1'b0;
    if (n != 64'd2 && !n[0]) return 1'b0;
    nm1 = n - 64'd1;
    d = nm1;
    while (d != 64'd0 && !d[0]) d = d >> 1;
    k = NUM_BASES < 1 ? 1 :
        (NUM_BASES > mrpt_pkg::TABLE_SIZE ? mrpt_pkg::TABLE_SIZE : NUM_BASES);
    for (int i = 0; i < k; i++) begin
      x = 64'(mrpt_pkg::BASE_TABLE[i]);
      if (n == x) return 1'b1;
      t = d;
      m = powmod(x, d, n);
      while (t != nm1 && m != 64'd1 && m != nm1) begin
        m = mulmod(m, m, n);
        t = t << 1;
      end
      if (m != nm1 && !t[0]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offer one candidate and record its verdict once the transaction is taken.
  task automatic send_candidate(logic [63:0] value);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = DATA_W'(value & VALUE_MASK);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_verdicts.push_back(primality_verdict(value));
    sent_count++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
  endtask

  task automatic drain;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_idling(int src, int snk);
    src_idle_pct  = src;
    snk_stall_pct = snk;
  endtask

  // Edge values, strong pseudoprimes and the largest primes of the range.
  task automatic test_directed;
    logic [63:0] vals [$];
    vals = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd15, 64'd21,
             64'd23, 64'd25, 64'd29, 64'd2047, 64'd3215031751,
             64'd3825123056546413051, 64'd2305843009213693951,
             64'd9223372036854775783, 64'h7FFF_FFFF_FFFF_FFFF,
             64'h4000_0000_0000_0000, 64'd1000000007};
    set_idling(0, 0);
    foreach (vals[i]) send_candidate(vals[i]);
    drain();
  endtask

  // Mostly narrow candidates so the run stays short; a few use the full width.
  task automatic test_random(int count);
    logic [63:0] value;
    int width;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) width = VALUE_WIDTH;
      else if ($urandom_range(99) < 30) width = $urandom_range(32, 21);
      else width = $urandom_range(20, 2);
      value = {$urandom, $urandom} & ((64'd1 << width) - 64'd1);
      if ($urandom_range(99) < 80) value[0] = 1'b1;
      send_candidate(value);
    end
    drain();
  endtask

  // Receiver stalls at random at the configured rate.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready = ($urandom_range(99) >= snk_stall_pct);
  end

  // Compare every delivered verdict with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: is_prime=%0b",
                                       m_axis_tdata[0]);
      end else begin
        bit exp_v;
        exp_v = pending_verdicts.pop_front();
        checked_count++;
        if (exp_v) prime_count++;
        if (m_axis_tdata[0] !== exp_v) begin
          mismatches++;
          if (mismatches <= 10) $display("is_prime mismatch on result %0d: expected %0b, got %0b",
                                         checked_count, exp_v, m_axis_tdata[0]);
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    sent_count    = 0;
    checked_count = 0;
    prime_count   = 0;
    idle_cycles   = 0;
    set_idling(0, 0);
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    set_idling(0, 0);
    test_random(25);
    set_idling(77, 0);
    test_random(25);
    set_idling(0, 77);
    test_random(25);
    set_idling(19, 19);
    test_random(25);

    repeat (200) @(negedge clk_i);
    $display("Tested %0d candidates (%0d prime) under four idling patterns,",
             sent_count, prime_count);
    $display("including pseudoprimes, edge values and full-width primes.");
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
